// File: design/cllfl_pkg.sv
// ----------------------------------------------------------------------------
// cllfl_pkg: shared types, constants and microcode for the circular list
// Slot store geometry, control word layout and the microprogram ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package cllfl_pkg;

  localparam int NODE_SLOTS = 8;
  localparam int SLOT_W     = $clog2(NODE_SLOTS);
  localparam int CNT_W      = $clog2(NODE_SLOTS + 1);
  localparam int VAL_W      = 32;
  localparam int SLOT_OUT_W = 3;
  localparam int IN_W       = 40;
  localparam int OUT_W      = 40;
  localparam int UPC_W      = 5;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [1:0] {
    REQ_INS_FRONT,
    REQ_INS_BACK,
    REQ_DEL_TAIL,
    REQ_READ_ALL
  } req_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_OVERFLOW,
    ST_EMPTY
  } status_t;

  // read address source for both stores
  typedef enum logic [1:0] {
    RS_TAIL,
    RS_FREE,
    RS_CUR
  } rsel_t;

  // link store write: address <- data
  typedef enum logic [2:0] {
    LW_NONE,
    LW_SLOT_RLINK,   // link[slot] <- link[tail] just read
    LW_TAIL_SLOT,    // link[tail] <- slot
    LW_SLOT_SELF,    // link[slot] <- slot
    LW_PREV_FIRST,   // link[prev] <- first
    LW_SLOT_FREE     // link[slot] <- free head
  } lwr_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_TAKE,
    ACT_ALLOC,
    ACT_LINK_BACK,
    ACT_FIRST,
    ACT_DEL_START,
    ACT_WALK,
    ACT_TAIL_PREV,
    ACT_CLEAR,
    ACT_FREE,
    ACT_RD_INIT,
    ACT_RD_FIRST,
    ACT_RD_NEXT
  } act_t;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_RESULT,
    EM_READ,
    EM_OVF,
    EM_EMPTY
  } emit_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_LIST_EMPTY,
    C_RLINK_TAIL,
    C_CUR_TAIL,
    C_RD_MORE
  } cond_t;

  typedef enum logic [UPC_W-1:0] {
    U_IDLE,
    U_I0,
    U_I1,
    U_I2,
    U_I3,
    U_I_FIRST,
    U_I_EMIT,
    U_D0,
    U_D1,
    U_W0,
    U_W1,
    U_D_FIX,
    U_D_ONE,
    U_D_FREE,
    U_D_EMIT,
    U_R0,
    U_R1,
    U_R2,
    U_R3,
    U_E_OVF,
    U_E_EMPTY
  } upc_t;

  typedef struct packed {
    rsel_t   rsel;
    lwr_t    lwr;
    logic    vwr;
    act_t    act;
    emit_t   emit;
    cond_t   cond;
    upc_t    target;
    logic    done;     // fall back to idle when the jump is not taken
  } uword_t;

  typedef struct packed {
    logic full;
    logic nonempty;
    logic rlink_tail;
    logic cur_tail;
    logic rd_more;
    logic out_free;
  } dp_stat_t;

  localparam uword_t UW_NOP = '{
    rsel: RS_TAIL, lwr: LW_NONE, vwr: 1'b0, act: ACT_NONE,
    emit: EM_NONE, cond: C_NEVER, target: U_IDLE, done: 1'b1
  };

  function automatic slot_t next_slot(slot_t s);
    if (s == slot_t'(NODE_SLOTS - 1)) begin
      return '0;
    end
    return slot_t'(s + 1'b1);
  endfunction

  function automatic logic [SLOT_OUT_W-1:0] slot_out(slot_t s);
    logic [SLOT_W+SLOT_OUT_W-1:0] t;
    t = {{SLOT_OUT_W{1'b0}}, s};
    return t[SLOT_OUT_W-1:0];
  endfunction

  // microprogram ROM
  function automatic uword_t ucode(upc_t a);
    uword_t w;
    w = UW_NOP;
    w.done = 1'b0;
    case (a)
      U_IDLE: begin
        w = UW_NOP;
      end
      U_I0: begin
        w.rsel = RS_FREE;
        w.act  = ACT_TAKE;
      end
      U_I1: begin
        w.rsel   = RS_TAIL;
        w.vwr    = 1'b1;
        w.act    = ACT_ALLOC;
        w.cond   = C_LIST_EMPTY;
        w.target = U_I_FIRST;
      end
      U_I2: begin
        w.lwr = LW_SLOT_RLINK;
      end
      U_I3: begin
        w.lwr    = LW_TAIL_SLOT;
        w.act    = ACT_LINK_BACK;
        w.cond   = C_ALWAYS;
        w.target = U_I_EMIT;
      end
      U_I_FIRST: begin
        w.lwr = LW_SLOT_SELF;
        w.act = ACT_FIRST;
      end
      U_I_EMIT: begin
        w.emit = EM_RESULT;
        w.done = 1'b1;
      end
      U_D0: begin
        w.rsel = RS_TAIL;
      end
      U_D1: begin
        w.act    = ACT_DEL_START;
        w.cond   = C_RLINK_TAIL;
        w.target = U_D_ONE;
      end
      U_W0: begin
        w.rsel   = RS_CUR;
        w.cond   = C_CUR_TAIL;
        w.target = U_D_FIX;
      end
      U_W1: begin
        w.act    = ACT_WALK;
        w.cond   = C_ALWAYS;
        w.target = U_W0;
      end
      U_D_FIX: begin
        w.lwr    = LW_PREV_FIRST;
        w.act    = ACT_TAIL_PREV;
        w.cond   = C_ALWAYS;
        w.target = U_D_FREE;
      end
      U_D_ONE: begin
        w.act = ACT_CLEAR;
      end
      U_D_FREE: begin
        w.lwr = LW_SLOT_FREE;
        w.act = ACT_FREE;
      end
      U_D_EMIT: begin
        w.emit = EM_RESULT;
        w.done = 1'b1;
      end
      U_R0: begin
        w.rsel = RS_TAIL;
        w.act  = ACT_RD_INIT;
      end
      U_R1: begin
        w.act = ACT_RD_FIRST;
      end
      U_R2: begin
        w.rsel = RS_CUR;
      end
      U_R3: begin
        w.rsel   = RS_CUR;
        w.emit   = EM_READ;
        w.act    = ACT_RD_NEXT;
        w.cond   = C_RD_MORE;
        w.target = U_R2;
        w.done   = 1'b1;
      end
      U_E_OVF: begin
        w.emit = EM_OVF;
        w.done = 1'b1;
      end
      U_E_EMPTY: begin
        w.emit = EM_EMPTY;
        w.done = 1'b1;
      end
      default: begin
        w = UW_NOP;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: design/circular_list_with_free_list.sv
// ----------------------------------------------------------------------------
// circular_list_with_free_list: circular linked list over a slot store
// Insert front/back, delete tail and read-all on a store with a free list.
// ----------------------------------------------------------------------------
// One request is processed at a time by a microcoded sequencer over a single
// read port per store. Delete walks the links to reach the tail's
// predecessor unless the list holds one element. Overflow and empty are
// reported as error results. Results go out through a register, so the
// next request is taken while the last result waits; a result stalled at
// the output stalls only the step that emits. After reset the store holds
// nothing and all slots are free; no clearing pass is needed.
`default_nettype none

module circular_list_with_free_list import cllfl_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,   // req_type[1:0], item_value[33:2]
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // status[1:0], value[33:2], slot[36:34]
  output logic                  m_tlast    // last_of_run
);

  logic                   in_xfer;
  req_t                   req;
  uword_t                 ctrl;
  dp_stat_t               stat;
  status_t                out_status;
  logic [VAL_W-1:0]       out_value;
  logic [SLOT_OUT_W-1:0]  out_slot;

  assign in_xfer = s_tvalid && s_tready;
  assign req     = req_t'(s_tdata[1:0]);

  cllfl_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_xfer  (in_xfer),
    .req      (req),
    .stat     (stat),
    .in_ready (s_tready),
    .ctrl     (ctrl)
  );

  cllfl_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_xfer    (in_xfer),
    .in_req     (req),
    .in_val     (s_tdata[VAL_W+1:2]),
    .ctrl       (ctrl),
    .out_ready  (m_tready),
    .stat       (stat),
    .out_valid  (m_tvalid),
    .out_status (out_status),
    .out_value  (out_value),
    .out_slot   (out_slot),
    .out_last   (m_tlast)
  );

  assign m_tdata = {{(OUT_W - 2 - VAL_W - SLOT_OUT_W){1'b0}}, out_slot, out_value,
                    out_status};

endmodule

`default_nettype wire

// File: design/cllfl_seq.sv
// ----------------------------------------------------------------------------
// cllfl_seq: microcode sequencer
// Step counter, request dispatch and conditional jumps over the ROM.
// ----------------------------------------------------------------------------
`default_nettype none

module cllfl_seq import cllfl_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_xfer,
  input  wire req_t     req,
  input  wire dp_stat_t stat,
  output logic          in_ready,
  output uword_t        ctrl
);

  upc_t   upc, upc_next;
  uword_t word;
  logic   go;
  logic   cond_ok;

  assign word = ucode(upc);
  // a step that emits waits for the output register
  assign go = (word.emit == EM_NONE) || stat.out_free;

  always_comb begin
    case (word.cond)
      C_NEVER:      cond_ok = 1'b0;
      C_ALWAYS:     cond_ok = 1'b1;
      C_LIST_EMPTY: cond_ok = !stat.nonempty;
      C_RLINK_TAIL: cond_ok = stat.rlink_tail;
      C_CUR_TAIL:   cond_ok = stat.cur_tail;
      C_RD_MORE:    cond_ok = stat.rd_more;
      default:      cond_ok = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    upc_next = upc;
    if (upc == U_IDLE) begin
      if (in_xfer) begin
        case (req)
          REQ_INS_FRONT, REQ_INS_BACK: upc_next = stat.full ? U_E_OVF : U_I0;
          REQ_DEL_TAIL:                upc_next = stat.nonempty ? U_D0 : U_E_EMPTY;
          REQ_READ_ALL:                upc_next = stat.nonempty ? U_R0 : U_E_EMPTY;
          default:                     upc_next = U_IDLE;
        endcase
      end
    end else if (go) begin
      if (cond_ok) begin
        upc_next = word.target;
      end else if (word.done) begin
        upc_next = U_IDLE;
      end else begin
        upc_next = upc_t'(upc + 1'b1);
      end
    end
  end

  // control outputs; a stalled step keeps its read address only
  always_comb begin
    ctrl     = word;
    in_ready = (upc == U_IDLE);
    if (!go) begin
      ctrl.lwr  = LW_NONE;
      ctrl.vwr  = 1'b0;
      ctrl.act  = ACT_NONE;
      ctrl.emit = EM_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

`default_nettype wire

// File: design/cllfl_dp.sv
// ----------------------------------------------------------------------------
// cllfl_dp: list datapath
// Link and value stores, list pointers, walk registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cllfl_dp import cllfl_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_xfer,
  input  wire req_t                  in_req,
  input  wire logic [VAL_W-1:0]      in_val,
  input  wire uword_t                ctrl,
  input  wire logic                  out_ready,
  output dp_stat_t                   stat,
  output logic                       out_valid,
  output status_t                    out_status,
  output logic [VAL_W-1:0]           out_value,
  output logic [SLOT_OUT_W-1:0]      out_slot,
  output logic                       out_last
);

  slot_t             tail, free_head, slot_r, first, prev, cur, k;
  logic [CNT_W-1:0]  cnt;
  logic              nonempty;
  req_t              req_r;
  logic [VAL_W-1:0]  dval;

  slot_t             rlink;
  logic [VAL_W-1:0]  rval;
  slot_t             lmem [NODE_SLOTS];
  logic [NODE_SLOTS-1:0] lvalid;   // unwritten links read as the reset chain
  logic [VAL_W-1:0]  vmem [NODE_SLOTS];

  slot_t             raddr, lwa, lwd;
  logic              lwe;
  logic              rd_last;

  always_comb begin
    case (ctrl.rsel)
      RS_TAIL: raddr = tail;
      RS_FREE: raddr = free_head;
      RS_CUR:  raddr = cur;
      default: raddr = tail;
    endcase
  end

  always_comb begin
    lwe = 1'b1;
    lwa = slot_r;
    lwd = slot_r;
    case (ctrl.lwr)
      LW_SLOT_RLINK: lwd = rlink;
      LW_TAIL_SLOT:  lwa = tail;
      LW_SLOT_SELF:  lwd = slot_r;
      LW_PREV_FIRST: begin
        lwa = prev;
        lwd = first;
      end
      LW_SLOT_FREE:  lwd = free_head;
      default:       lwe = 1'b0;
    endcase
  end

  assign rd_last = (cur == tail) || (k == slot_t'(NODE_SLOTS - 1));

  always_comb begin
    stat.full       = (cnt == CNT_W'(NODE_SLOTS));
    stat.nonempty   = nonempty;
    stat.rlink_tail = (rlink == tail);
    stat.cur_tail   = (cur == tail);
    stat.rd_more    = !rd_last;
    stat.out_free   = !out_valid || out_ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tail      <= '0;
      free_head <= '0;
      cnt       <= '0;
      nonempty  <= 1'b0;
      lvalid    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (lwe) begin
        lvalid[lwa] <= 1'b1;
      end
      case (ctrl.act)
        ACT_ALLOC: begin
          free_head <= rlink;
          cnt       <= CNT_W'(cnt + 1'b1);
        end
        ACT_LINK_BACK: begin
          if (req_r == REQ_INS_BACK) begin
            tail <= slot_r;
          end
        end
        ACT_FIRST: begin
          tail     <= slot_r;
          nonempty <= 1'b1;
        end
        ACT_TAIL_PREV: tail <= prev;
        ACT_CLEAR: begin
          tail     <= '0;
          nonempty <= 1'b0;
        end
        ACT_FREE: begin
          free_head <= slot_r;
          cnt       <= CNT_W'(cnt - 1'b1);
        end
        default: ;
      endcase
      if (ctrl.emit != EM_NONE) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // walk and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r <= in_req;
      dval  <= in_val;
    end
    case (ctrl.act)
      ACT_TAKE: slot_r <= free_head;
      ACT_DEL_START: begin
        dval   <= rval;
        first  <= rlink;
        prev   <= rlink;
        cur    <= rlink;
        slot_r <= tail;
      end
      ACT_WALK: begin
        prev <= cur;
        cur  <= rlink;
      end
      ACT_RD_INIT:  k <= '0;
      ACT_RD_FIRST: cur <= rlink;
      ACT_RD_NEXT: begin
        cur <= rlink;
        k   <= slot_t'(k + 1'b1);
      end
      default: ;
    endcase
    case (ctrl.emit)
      EM_RESULT: begin
        out_status <= ST_OK;
        out_value  <= dval;
        out_slot   <= slot_out(slot_r);
        out_last   <= 1'b1;
      end
      EM_READ: begin
        out_status <= ST_OK;
        out_value  <= rval;
        out_slot   <= slot_out(cur);
        out_last   <= rd_last;
      end
      EM_OVF: begin
        out_status <= ST_OVERFLOW;
        out_value  <= '0;
        out_slot   <= '0;
        out_last   <= 1'b1;
      end
      EM_EMPTY: begin
        out_status <= ST_EMPTY;
        out_value  <= '0;
        out_slot   <= '0;
        out_last   <= 1'b1;
      end
      default: ;
    endcase
  end

  // stores: one write and one registered read each per cycle
  always_ff @(posedge clk) begin
    if (lwe) begin
      lmem[lwa] <= lwd;
    end
    if (ctrl.vwr) begin
      vmem[slot_r] <= dval;
    end
    rlink <= lvalid[raddr] ? lmem[raddr] : next_slot(raddr);
    rval  <= vmem[raddr];
  end

endmodule

`default_nettype wire

// File: design/cllfl_checker.sv
// ----------------------------------------------------------------------------
// cllfl_checker: port-level checks for the circular list
// Request handshake, result framing and status encoding.
// ----------------------------------------------------------------------------
`default_nettype none

module cllfl_checker import cllfl_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_tvalid,
  input wire logic             s_tready,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata,
  input wire logic             m_tlast
);

  // every request needs more work after the transfer, so the input drops ready
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on two consecutive cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // error results are always single-transfer runs
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != ST_OK) |-> m_tlast)
    else $error("error result without last");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == ST_OK) || (m_tdata[1:0] == ST_OVERFLOW) ||
                 (m_tdata[1:0] == ST_EMPTY))
    else $error("undefined status code");

endmodule

bind circular_list_with_free_list cllfl_checker u_chk (.*);

`default_nettype wire
